// ===== hdl/usage_step_profile_unit_defines.svh =====
// assertion helpers for the bound checker module usp_check
`ifndef USAGE_STEP_PROFILE_UNIT_DEFINES_SVH
`define USAGE_STEP_PROFILE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define USP_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define USP_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/usp_pkg.sv =====
package usp_pkg;

    localparam int MAX_BREAKS_DEF = 64;
    localparam int TIME_W         = 32;
    localparam int LEVEL_W        = 32;
    localparam int ENTRY_W        = TIME_W + LEVEL_W;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // what goes into the destination table on a write
    localparam logic [1:0] EMIT_COPY  = 2'd0;
    localparam logic [1:0] EMIT_SHIFT = 2'd1;
    localparam logic [1:0] EMIT_BEGIN = 2'd2;
    localparam logic [1:0] EMIT_END   = 2'd3;

    // how an operation closes
    localparam logic [1:0] FIN_TRIV   = 2'd0;
    localparam logic [1:0] FIN_COMMIT = 2'd1;
    localparam logic [1:0] FIN_FOUND  = 2'd2;
    localparam logic [1:0] FIN_NONE   = 2'd3;

    typedef struct packed {
        logic       start;
        logic       consume;
        logic       emit;
        logic [1:0] emit_kind;
        logic       take;
        logic       hit_b;
        logic       drop_mrg;
        logic       ld_win;
        logic       fin;
        logic [1:0] fin_kind;
    } usp_cmd_t;

    typedef struct packed {
        logic trivial;
        logic is_query;
        logic is_remove;
        logic at_end;
        logic zero_idx;
        logic t_lt_b;
        logic t_eq_b;
        logic t_le_e;
        logic t_lt_e;
        logic t_eq_e;
        logic vd_eq_pv;
        logic v_eq_pv;
        logic p_less;
        logic v_less;
        logic t_ge_en;
        logic out_free;
    } usp_stat_t;

endpackage

// ===== hdl/usage_step_profile_unit.sv =====
// Step profile of usage over time kept as a sorted table of breakpoints (time, level).
// One operation is in flight at a time; s_tready is high only while the unit is idle,
// and a finished result waits in the output register without holding up the next beat.
// Each operation walks the table through one registered-read port, with a read state and
// a processing state per breakpoint visited, so add and remove run to the end of the table
// and a query stops as soon as a window is found. Add and remove
// copy the table into a second bank while editing it and switch banks at the end, so a
// rejected operation leaves the table untouched. Writing cfg_wr_data sets the level of
// the first segment and clears the table; no sweep is needed after reset.
module usage_step_profile_unit
    import usp_pkg::*;
#(
    parameter int MAX_BREAKS = MAX_BREAKS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [3*TIME_W-1:0]       s_tdata,     // begin_time, end_or_span, amount
    input  logic [1:0]                s_tuser,     // op
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [TIME_W-1:0]         m_tdata,     // found_time
    output logic [1:0]                m_tuser,     // status
    input  logic                      cfg_wr_en,
    input  logic signed [LEVEL_W-1:0] cfg_wr_data
);

    usp_cmd_t  cmd;
    usp_stat_t stat;

    usp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    usp_dp #(.MAX_BREAKS(MAX_BREAKS)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ===== hdl/usp_ram.sv =====
module usp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/usp_ctrl.sv =====
module usp_ctrl
    import usp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  usp_stat_t stat,
    output usp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_PROC  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    localparam logic [2:0] PH_PRE  = 3'd0;
    localparam logic [2:0] PH_MRG  = 3'd1;
    localparam logic [2:0] PH_LOOP = 3'd2;
    localparam logic [2:0] PH_POST = 3'd3;
    localparam logic [2:0] PH_FIND = 3'd4;
    localparam logic [2:0] PH_QA   = 3'd5;
    localparam logic [2:0] PH_QB   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [1:0] fin_kind_reg, fin_kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_PRE;
            fin_kind_reg <= FIN_TRIV;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            fin_kind_reg <= fin_kind_next;
        end
    end

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        phase_next    = phase_reg;
        fin_kind_next = fin_kind_reg;
        s_tready      = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                if (stat.trivial) begin
                    fin_kind_next = FIN_TRIV;
                    state_next    = S_FIN;
                end else begin
                    phase_next = stat.is_query ? PH_FIND : PH_PRE;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_PROC;
            end
            S_PROC: begin
                // end of table behaves like a breakpoint later than any time
                unique case (phase_reg)
                    PH_PRE: begin
                        if (!stat.at_end && stat.t_lt_b) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = EMIT_COPY;
                            cmd.take      = 1'b1;
                            cmd.consume   = 1'b1;
                            state_next    = S_RD;
                        end else if (!stat.at_end && stat.t_eq_b) begin
                            cmd.hit_b  = 1'b1;
                            phase_next = PH_MRG;
                        end else begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = EMIT_BEGIN;
                            phase_next    = PH_MRG;
                        end
                    end
                    PH_MRG: begin
                        phase_next = PH_LOOP;
                        if (!stat.at_end && stat.t_le_e && stat.vd_eq_pv) begin
                            cmd.drop_mrg = 1'b1;
                            cmd.consume  = 1'b1;
                            state_next   = S_RD;
                        end
                    end
                    PH_LOOP: begin
                        if (stat.at_end) begin
                            if (stat.is_remove) begin
                                fin_kind_next = FIN_COMMIT;
                                state_next    = S_FIN;
                            end else begin
                                cmd.emit      = 1'b1;
                                cmd.emit_kind = EMIT_END;
                                phase_next    = PH_POST;
                            end
                        end else if (stat.t_lt_e) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = EMIT_SHIFT;
                            cmd.consume   = 1'b1;
                            state_next    = S_RD;
                        end else if (stat.t_eq_e) begin
                            phase_next = PH_POST;
                            if (stat.v_eq_pv) begin
                                cmd.consume = 1'b1;
                                state_next  = S_RD;
                            end
                        end else begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = EMIT_END;
                            phase_next    = PH_POST;
                        end
                    end
                    PH_POST: begin
                        if (stat.at_end) begin
                            fin_kind_next = FIN_COMMIT;
                            state_next    = S_FIN;
                        end else begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = EMIT_COPY;
                            cmd.take      = 1'b1;
                            cmd.consume   = 1'b1;
                            state_next    = S_RD;
                        end
                    end
                    PH_FIND: begin
                        if (stat.zero_idx || (!stat.at_end && stat.t_lt_b)) begin
                            cmd.take    = 1'b1;
                            cmd.consume = 1'b1;
                            state_next  = S_RD;
                        end else begin
                            phase_next = PH_QA;
                        end
                    end
                    PH_QA: begin
                        if (!stat.p_less) begin
                            if (stat.at_end) begin
                                fin_kind_next = FIN_NONE;
                                state_next    = S_FIN;
                            end else begin
                                cmd.take    = 1'b1;
                                cmd.consume = 1'b1;
                                state_next  = S_RD;
                            end
                        end else begin
                            cmd.ld_win = 1'b1;
                            phase_next = PH_QB;
                        end
                    end
                    PH_QB: begin
                        if (stat.at_end || stat.t_ge_en) begin
                            fin_kind_next = FIN_FOUND;
                            state_next    = S_FIN;
                        end else begin
                            cmd.take    = 1'b1;
                            cmd.consume = 1'b1;
                            state_next  = S_RD;
                            // window start holds while the level stays below the limit
                            phase_next  = stat.v_less ? PH_QB : PH_QA;
                        end
                    end
                    default: begin
                        phase_next = PH_PRE;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.fin      = 1'b1;
                    cmd.fin_kind = fin_kind_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/usp_dp.sv =====
module usp_dp
    import usp_pkg::*;
#(
    parameter int MAX_BREAKS = MAX_BREAKS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [3*TIME_W-1:0]       s_tdata,
    input  logic [1:0]                s_tuser,
    input  logic                      cfg_wr_en,
    input  logic signed [LEVEL_W-1:0] cfg_wr_data,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [TIME_W-1:0]         m_tdata,
    output logic [1:0]                m_tuser,
    input  usp_cmd_t                  cmd,
    output usp_stat_t                 stat
);

    localparam int AW = $clog2(MAX_BREAKS);
    localparam int CW = $clog2(MAX_BREAKS + 1);

    logic [1:0]         op_reg;
    logic [TIME_W-1:0]  b_reg, e_reg;
    logic [LEVEL_W-1:0] amt_reg;
    logic [LEVEL_W-1:0] init_level_reg;
    logic [CW-1:0]      count_reg, idx_reg, wcnt_reg;
    logic               bank_reg, ovf_reg, rd_zero_reg;
    logic [TIME_W-1:0]  p_t_reg, st_reg, en_reg;
    logic [LEVEL_W-1:0] p_v_reg, pv_reg, ov_reg;
    logic               m_valid_reg;
    logic [TIME_W-1:0]  m_time_reg;
    logic [1:0]         m_status_reg;

    logic [ENTRY_W-1:0] rdata0, rdata1, rdata, wdata;
    logic               wr, we0, we1;
    logic [TIME_W-1:0]  cur_t, w_t, st_c, en_c;
    logic [LEVEL_W-1:0] cur_v, w_v, delta, cur_vd, p_vd;
    logic [TIME_W:0]    win_sum;
    logic               is_remove, commit_ok;

    assign is_remove = (op_reg == OP_REMOVE);
    assign delta     = is_remove ? (LEVEL_W'(0) - amt_reg) : amt_reg;

    // entry 0 is always (time 0, initial level) and lives in a register
    assign rdata  = bank_reg ? rdata1 : rdata0;
    assign cur_t  = rd_zero_reg ? '0 : rdata[TIME_W-1:0];
    assign cur_v  = rd_zero_reg ? init_level_reg : rdata[ENTRY_W-1:TIME_W];
    assign cur_vd = cur_v + delta;
    assign p_vd   = p_v_reg + delta;

    always_comb begin
        case (cmd.emit_kind)
            EMIT_COPY: begin
                w_t = cur_t;
                w_v = cur_v;
            end
            EMIT_SHIFT: begin
                w_t = cur_t;
                w_v = cur_vd;
            end
            EMIT_BEGIN: begin
                w_t = b_reg;
                w_v = p_vd;
            end
            default: begin
                w_t = e_reg;
                w_v = ov_reg;
            end
        endcase
    end

    assign wdata = {w_v, w_t};
    assign wr    = cmd.emit && (wcnt_reg < CW'(MAX_BREAKS));
    assign we0   = wr && bank_reg;
    assign we1   = wr && !bank_reg;

    usp_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BREAKS)) u_bank0 (
        .aclk  (aclk),
        .we    (we0),
        .waddr (wcnt_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata0)
    );

    usp_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BREAKS)) u_bank1 (
        .aclk  (aclk),
        .we    (we1),
        .waddr (wcnt_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata1)
    );

    // query window: start no earlier than begin, end saturates at all ones
    assign st_c    = (p_t_reg > b_reg) ? p_t_reg : b_reg;
    assign win_sum = {1'b0, st_c} + {1'b0, e_reg};
    assign en_c    = win_sum[TIME_W] ? '1 : win_sum[TIME_W-1:0];

    assign commit_ok = cmd.fin && (cmd.fin_kind == FIN_COMMIT) && !ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_level_reg <= '0;
            count_reg      <= CW'(1);
            bank_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                init_level_reg <= cfg_wr_data;
                count_reg      <= CW'(1);
            end else if (commit_ok) begin
                count_reg <= wcnt_reg;
            end
            if (commit_ok) begin
                bank_reg <= !bank_reg;
            end
            if (cmd.fin) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_zero_reg <= (idx_reg == '0);
        if (cmd.start) begin
            op_reg   <= s_tuser;
            b_reg    <= s_tdata[TIME_W-1:0];
            e_reg    <= s_tdata[2*TIME_W-1:TIME_W];
            amt_reg  <= s_tdata[3*TIME_W-1:2*TIME_W];
            idx_reg  <= '0;
            wcnt_reg <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            if (cmd.consume) begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (wr) begin
                wcnt_reg <= wcnt_reg + CW'(1);
            end else if (cmd.emit) begin
                ovf_reg <= 1'b1;
            end
        end
        if (cmd.take) begin
            p_t_reg <= cur_t;
            p_v_reg <= cur_v;
        end
        if (cmd.emit && cmd.emit_kind == EMIT_BEGIN) begin
            pv_reg <= p_vd;
            ov_reg <= p_v_reg;
        end else if (cmd.emit && cmd.emit_kind == EMIT_SHIFT) begin
            pv_reg <= cur_vd;
            ov_reg <= cur_v;
        end else if (cmd.hit_b) begin
            pv_reg <= p_v_reg;
            ov_reg <= p_v_reg;
        end else if (cmd.drop_mrg) begin
            ov_reg <= cur_v;
        end
        if (cmd.ld_win) begin
            st_reg <= st_c;
            en_reg <= en_c;
        end
        if (cmd.fin) begin
            case (cmd.fin_kind)
                FIN_COMMIT: begin
                    m_time_reg   <= '0;
                    m_status_reg <= ovf_reg ? ST_FULL : ST_OK;
                end
                FIN_FOUND: begin
                    m_time_reg   <= st_reg;
                    m_status_reg <= ST_OK;
                end
                FIN_NONE: begin
                    m_time_reg   <= '0;
                    m_status_reg <= ST_NONE;
                end
                default: begin
                    m_time_reg   <= '0;
                    m_status_reg <= ST_OK;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_time_reg;
    assign m_tuser  = m_status_reg;

    always_comb begin
        stat.trivial   = (op_reg == 2'd3)
                       || (op_reg == OP_ADD && (b_reg == '0 || e_reg <= b_reg))
                       || (op_reg == OP_REMOVE && b_reg == '0);
        stat.is_query  = (op_reg == OP_QUERY);
        stat.is_remove = is_remove;
        stat.at_end    = (idx_reg == count_reg);
        stat.zero_idx  = rd_zero_reg;
        stat.t_lt_b    = (cur_t < b_reg);
        stat.t_eq_b    = (cur_t == b_reg);
        stat.t_le_e    = is_remove || (cur_t <= e_reg);
        stat.t_lt_e    = is_remove || (cur_t < e_reg);
        stat.t_eq_e    = !is_remove && (cur_t == e_reg);
        stat.vd_eq_pv  = (cur_vd == pv_reg);
        stat.v_eq_pv   = (cur_v == pv_reg);
        stat.p_less    = ($signed(p_v_reg) < $signed(amt_reg));
        stat.v_less    = ($signed(cur_v) < $signed(amt_reg));
        stat.t_ge_en   = (cur_t >= en_reg);
        stat.out_free  = !m_valid_reg || m_tready;
    end

endmodule

// ===== hdl/usp_check.sv =====
`include "usage_step_profile_unit_defines.svh"

module usp_check
    import usp_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [TIME_W-1:0] m_tdata,
    input logic [1:0]        m_tuser
);

    `USP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
    `USP_ASSERT_IMPL(a_status_code, aclk, aresetn, m_tvalid, m_tuser == ST_OK || m_tuser == ST_NONE || m_tuser == ST_FULL, "undefined status code")
    `USP_ASSERT_IMPL(a_time_zero, aclk, aresetn, m_tvalid && (m_tuser == ST_NONE || m_tuser == ST_FULL), m_tdata == '0, "found time not zero on a miss or reject")
    `USP_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second beat taken while busy")

endmodule

bind usage_step_profile_unit usp_check u_usp_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/usp_checker.sv =====
module usp_checker
    import usp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [3*TIME_W-1:0]       s_tdata,
    input  logic [1:0]                s_tuser,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [TIME_W-1:0]         m_tdata,
    input  logic [1:0]                m_tuser,
    input  logic                      cfg_wr_en,
    input  logic signed [LEVEL_W-1:0] cfg_wr_data,
    output int                        fail_count,
    output int                        pending,
    output int                        result_count
);
    localparam int NB = MAX_BREAKS_DEF;
    localparam int WD = NB + 2;

    typedef struct packed {
        logic [TIME_W-1:0] found;
        logic [1:0]        status;
    } answer_t;

    logic [TIME_W-1:0]  bp_time [NB];
    logic [LEVEL_W-1:0] bp_level[NB];
    int                 bp_count;
    logic [TIME_W-1:0]  wk_time [WD];
    logic [LEVEL_W-1:0] wk_level[WD];
    int                 wk_count;
    answer_t            answers_due[$];

    function automatic bit level_below(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic int prev_break(int cnt, logic [31:0] at, bit use_work);
        int p;
        p = 0;
        while (p + 1 < cnt && (use_work ? wk_time[p+1] : bp_time[p+1]) < at) p++;
        return p;
    endfunction

    function automatic void wk_ins(int pos, logic [31:0] t, logic [31:0] v);
        if (wk_count >= WD || pos > wk_count) return;
        for (int i = wk_count; i > pos; i--) begin
            wk_time[i] = wk_time[i-1];
            wk_level[i] = wk_level[i-1];
        end
        wk_time[pos] = t;
        wk_level[pos] = v;
        wk_count++;
    endfunction

    function automatic void wk_del(int pos);
        if (pos >= wk_count) return;
        for (int i = pos; i < wk_count - 1; i++) begin
            wk_time[i] = wk_time[i+1];
            wk_level[i] = wk_level[i+1];
        end
        wk_count--;
    endfunction

    function automatic void apply_add(logic [31:0] b, logic [31:0] e, logic [31:0] amt);
        int p, n;
        logic [31:0] pv, ov;
        p = prev_break(wk_count, b, 1);
        n = p + 1;
        pv = wk_level[p];
        ov = pv;
        if (n >= wk_count || wk_time[n] > b) begin
            pv += amt;
            wk_ins(n, b, pv);
            n++;
        end
        if (n < wk_count && wk_time[n] <= e && wk_level[n] + amt == pv) begin
            ov = wk_level[n];
            wk_del(n);
        end
        while (n < wk_count && wk_time[n] < e) begin
            ov = wk_level[n];
            wk_level[n] += amt;
            pv = wk_level[n];
            n++;
        end
        if (n >= wk_count || wk_time[n] > e) wk_ins(n, e, ov);
        else if (wk_level[n] == pv) wk_del(n);
    endfunction

    function automatic void apply_remove(logic [31:0] b, logic [31:0] amt);
        int p, n;
        logic [31:0] pv;
        bit had_next;
        p = prev_break(wk_count, b, 1);
        n = p + 1;
        pv = wk_level[p];
        had_next = n < wk_count;
        if (!had_next || wk_time[n] > b) begin
            pv -= amt;
            wk_ins(n, b, pv);
            n++;
        end
        if (!had_next) return;
        if (n < wk_count && wk_level[n] - amt == pv) wk_del(n);
        while (n < wk_count) begin
            wk_level[n] -= amt;
            n++;
        end
    endfunction

    function automatic answer_t find_window(logic [31:0] after, logic [31:0] span,
                                            logic [31:0] lim);
        int p, n;
        logic [31:0] st, en;
        answer_t r;
        r = '0;
        p = prev_break(bp_count, after, 0);
        n = p + 1;
        forever begin
            while (!level_below(bp_level[p], lim)) begin
                if (n >= bp_count) begin
                    r.status = ST_NONE;
                    return r;
                end
                p = n;
                n++;
            end
            st = bp_time[p] > after ? bp_time[p] : after;
            en = (span > 32'hFFFF_FFFF - st) ? 32'hFFFF_FFFF : st + span;
            while (level_below(bp_level[p], lim)) begin
                if (n >= bp_count || bp_time[n] >= en) begin
                    r.found = st;
                    r.status = ST_OK;
                    return r;
                end
                p = n;
                n++;
            end
        end
    endfunction

    function automatic answer_t step_profile(logic [1:0] op, logic [31:0] b,
                                             logic [31:0] e, logic [31:0] amt);
        answer_t r;
        r = '0;
        r.status = ST_OK;
        if (op == OP_QUERY) begin
            r = find_window(b, e, amt);
        end else if ((op == OP_ADD && b != 0 && e > b) || (op == OP_REMOVE && b != 0)) begin
            wk_count = bp_count;
            for (int i = 0; i < NB; i++) begin
                wk_time[i] = bp_time[i];
                wk_level[i] = bp_level[i];
            end
            if (op == OP_ADD) apply_add(b, e, amt);
            else apply_remove(b, amt);
            if (wk_count > NB) begin
                r.status = ST_FULL;
            end else begin
                for (int i = 0; i < wk_count; i++) begin
                    bp_time[i] = wk_time[i];
                    bp_level[i] = wk_level[i];
                end
                bp_count = wk_count;
            end
        end
        return r;
    endfunction

    function automatic void clear_profile(logic [31:0] lvl);
        for (int i = 0; i < NB; i++) begin
            bp_time[i] = '0;
            bp_level[i] = '0;
        end
        bp_level[0] = lvl;
        bp_count = 1;
    endfunction

    always @(posedge aclk) begin
        answer_t want, got;
        if (!aresetn) begin
            clear_profile('0);
            answers_due.delete();
            fail_count <= 0;
            result_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.found = m_tdata;
                got.status = m_tuser;
                result_count <= result_count + 1;
                if (answers_due.size() == 0) begin
                    if (fail_count < 10) $display("unexpected beat: found %h status %0d",
                                                  got.found, got.status);
                    fail_count <= fail_count + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (want != got) begin
                        if (fail_count < 10)
                            $display("mismatch: expected found %h status %0d, got %h %0d",
                                     want.found, want.status, got.found, got.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                answers_due.push_back(step_profile(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                                   s_tdata[95:64]));
            if (cfg_wr_en) clear_profile(cfg_wr_data);
        end
        pending <= answers_due.size();
    end
endmodule

// ===== tb/tb.sv =====
module tb;
    import usp_pkg::*;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [3*TIME_W-1:0]       s_tdata = '0;
    logic [1:0]                s_tuser = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [TIME_W-1:0]         m_tdata;
    logic [1:0]                m_tuser;
    logic                      cfg_wr_en = 1'b0;
    logic signed [LEVEL_W-1:0] cfg_wr_data = '0;
    int                        fail_count, pending, result_count;
    int                        send_idle = 0, recv_stall = 0;
    longint                    cycle_count = 0;
    logic [31:0]               time_hi = 32'd200;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    usage_step_profile_unit u_top (.*);

    usp_checker u_chk (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 64'd4_000_000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_stall);

    // tvalid stays high from one beat to the next unless the sender idles
    task automatic send_beat(logic [1:0] op, logic [31:0] b, logic [31:0] e, logic [31:0] amt);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {amt, e, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);
    endtask

    task automatic set_initial_level(logic [31:0] lvl);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= lvl;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_time();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'hFFFF_FFFF - $urandom_range(20);
            2: return $urandom_range(3);
            default: return $urandom_range(time_hi);
        endcase
    endfunction

    function automatic logic [31:0] rand_amount();
        case ($urandom_range(7))
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return 32'h7FFF_FFFF - $urandom_range(3);
            default: return $urandom_range(20) - 10;
        endcase
    endfunction

    task automatic random_beat();
        logic [1:0]  op;
        logic [31:0] b, e;
        op = $urandom_range(19) == 0 ? 2'd3 : $urandom_range(2);
        b = rand_time();
        if (op == OP_QUERY) e = $urandom_range(3) == 0 ? $urandom : $urandom_range(60);
        else e = $urandom_range(4) == 0 ? rand_time() : b + $urandom_range(40);
        send_beat(op, b, e, rand_amount());
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // directed: extremes, each op, empty interval, zero begin, unused code
        send_beat(OP_QUERY, 32'd1, 32'd0, 32'd1);
        send_beat(OP_ADD, 32'd10, 32'd20, 32'd5);
        send_beat(OP_ADD, 32'd5, 32'd10, 32'd5);
        send_beat(OP_ADD, 32'd20, 32'd30, 32'd5);
        send_beat(OP_ADD, 32'd0, 32'd30, 32'd7);
        send_beat(OP_ADD, 32'd30, 32'd30, 32'd7);
        send_beat(OP_ADD, 32'd40, 32'd35, 32'd7);
        send_beat(OP_REMOVE, 32'd0, 32'd0, 32'd3);
        send_beat(OP_REMOVE, 32'd25, 32'hFFFF_FFFF, 32'h8000_0000);
        send_beat(OP_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_beat(OP_QUERY, 32'd1, 32'd4, 32'd3);
        send_beat(OP_QUERY, 32'd2, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_beat(OP_QUERY, 32'hFFFF_FFFF, 32'd100, 32'h8000_0000);
        send_beat(OP_QUERY, 32'd3, 32'd0, 32'd6);
        send_beat(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_initial_level(32'h8000_0000);
        send_beat(OP_REMOVE, 32'd50, 32'd0, 32'd1);
        send_beat(OP_QUERY, 32'd1, 32'd10, 32'h8000_0001);
        // fill the table until add overflows
        for (int i = 0; i < 40; i++)
            send_beat(OP_ADD, 32'(100 + 4 * i), 32'(102 + 4 * i), 32'(i + 1));
        drain_results();
        set_initial_level(32'h7FFF_FFFF);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 78; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 78; end
                default: begin send_idle = 12; recv_stall = 12; end
            endcase
            for (int k = 0; k < 3; k++) begin
                set_initial_level(k == 0 ? rand_amount() : $urandom);
                time_hi = k == 2 ? 32'd5000 : 32'd200;
                for (int i = 0; i < 125; i++) random_beat();
            end
        end
        send_idle = 0;
        recv_stall = 0;
        drain_results();
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== usage_step_profile_unit.f =====
+incdir+hdl
hdl/usp_pkg.sv
hdl/usp_ram.sv
hdl/usp_ctrl.sv
hdl/usp_dp.sv
hdl/usage_step_profile_unit.sv
hdl/usp_check.sv
tb/usp_checker.sv
tb/tb.sv
